// ===== src/hpc_pkg.sv =====
// ============================================================================
// hpc_pkg - shared types and constants for the hashed phrase counter
// Sizes of the stores, result codes and the command/status bundles that
// join the controller and the datapath.
// ============================================================================
package hpc_pkg;

    localparam int CHAR_W          = 21;
    localparam int CFG_W           = 11;
    localparam int BUCKET_DEPTH    = 1024;
    localparam int BKT_W           = $clog2(BUCKET_DEPTH);
    localparam int ENTRY_DEPTH     = 65536;
    localparam int ENT_W           = $clog2(ENTRY_DEPTH);
    localparam int KEY_STORE_DEPTH = 262144;
    localparam int KEY_AW          = $clog2(KEY_STORE_DEPTH);
    localparam int MAX_KEY_LEN     = 512;
    localparam int PB_AW           = $clog2(MAX_KEY_LEN);
    localparam int LEN_W           = PB_AW + 1;
    localparam int CNT_W           = 32;
    localparam int HASH_W          = 64;
    localparam int DCNT_W          = $clog2(HASH_W) + 1;

    localparam logic [HASH_W-1:0] HASH_SEED     = 64'd5381;
    localparam logic [CFG_W-1:0]  BUCKET_RESET  = 11'd1024;
    localparam logic [CFG_W-1:0]  BUCKET_MAX    = 11'd1024;

    // result status codes
    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_NEW      = 3'd1;
    localparam logic [2:0] ST_ENT_FULL = 3'd2;
    localparam logic [2:0] ST_KEY_FULL = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic       clr_step;   // zero one bucket head, advance sweep
        logic       char_take;  // input beat accepted
        logic       div_start;  // load hash into the remainder unit
        logic       div_step;   // one quotient bit
        logic       head_load;  // current entry <= bucket head
        logic       ent_next;   // follow chain link
        logic       idx_clr;    // character index <= 0
        logic       idx_inc;    // character index + 1
        logic       cnt_wr;     // write incremented count
        logic       cp_wr;      // copy one key character
        logic       ins_wr;     // write new entry record
        logic       link_wr;    // link new entry, bump fill pointers
        logic       res_load;   // latch result fields
        logic [2:0] res_code;
        logic       out_load;   // move result to the output register
        logic       phrase_clr; // return phrase state to reset values
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic s_valid;
        logic s_last;
        logic clr_last;
        logic div_done;
        logic too_long;
        logic e_zero;
        logic len_eq;
        logic key_eq;
        logic idx_last;
        logic ent_full;
        logic key_full;
        logic out_busy;
    } t_sts;

endpackage

// ===== src/hpc_ctrl.sv =====
// ============================================================================
// hpc_ctrl - phrase counter sequencer
// One-hot state machine: bucket clear sweep, character intake, hash
// reduction, chain walk, key compare, key copy, insert and result hand-off.
// ============================================================================
module hpc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hpc_pkg::t_sts i_sts,
    output hpc_pkg::t_cmd o_cmd,
    output logic          o_ready
);

    typedef enum logic [16:0] {
        S_CLEAR  = 17'h00001,
        S_IDLE   = 17'h00002,
        S_START  = 17'h00004,
        S_DIV    = 17'h00008,
        S_HEAD   = 17'h00010,
        S_HEADW  = 17'h00020,
        S_CHK    = 17'h00040,
        S_ENTW   = 17'h00080,
        S_CMPRD  = 17'h00100,
        S_CMPEQ  = 17'h00200,
        S_CNT    = 17'h00400,
        S_INSCHK = 17'h00800,
        S_CPRD   = 17'h01000,
        S_CPWR   = 17'h02000,
        S_INS    = 17'h04000,
        S_LINK   = 17'h08000,
        S_EMIT   = 17'h10000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_sts.s_valid) begin
                    o_cmd.char_take = 1'b1;
                    if (i_sts.s_last) n_state = S_START;
                end
            end
            S_START: begin
                if (i_sts.too_long) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = hpc_pkg::ST_TOO_LONG;
                    n_state        = S_EMIT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_HEAD;
                else o_cmd.div_step = 1'b1;
            end
            // head read address is the bucket, data lands next cycle
            S_HEAD: n_state = S_HEADW;
            S_HEADW: begin
                o_cmd.head_load = 1'b1;
                n_state         = S_CHK;
            end
            S_CHK: begin
                if (i_sts.e_zero) n_state = S_INSCHK;
                else n_state = S_ENTW;
            end
            S_ENTW: begin
                if (i_sts.len_eq) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_CMPRD;
                end else begin
                    o_cmd.ent_next = 1'b1;
                    n_state        = S_CHK;
                end
            end
            S_CMPRD: n_state = S_CMPEQ;
            S_CMPEQ: begin
                if (!i_sts.key_eq) begin
                    o_cmd.ent_next = 1'b1;
                    n_state        = S_CHK;
                end else if (i_sts.idx_last) begin
                    n_state = S_CNT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_CMPRD;
                end
            end
            S_CNT: begin
                o_cmd.cnt_wr   = 1'b1;
                o_cmd.res_load = 1'b1;
                o_cmd.res_code = hpc_pkg::ST_FOUND;
                n_state        = S_EMIT;
            end
            S_INSCHK: begin
                if (i_sts.ent_full) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = hpc_pkg::ST_ENT_FULL;
                    n_state        = S_EMIT;
                end else if (i_sts.key_full) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = hpc_pkg::ST_KEY_FULL;
                    n_state        = S_EMIT;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_CPRD;
                end
            end
            S_CPRD: n_state = S_CPWR;
            S_CPWR: begin
                o_cmd.cp_wr = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_INS;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_CPRD;
                end
            end
            S_INS: begin
                o_cmd.ins_wr   = 1'b1;
                o_cmd.res_load = 1'b1;
                o_cmd.res_code = hpc_pkg::ST_NEW;
                n_state        = S_LINK;
            end
            S_LINK: begin
                o_cmd.link_wr = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.phrase_clr = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

// ===== src/hpc_dp.sv =====
// ============================================================================
// hpc_dp - phrase counter datapath
// Hash accumulator, phrase buffer, bit-serial hash reduction, the bucket,
// entry and key memories, and the output register.
// ============================================================================
module hpc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hpc_pkg::t_cmd                 i_cmd,
    output hpc_pkg::t_sts                 o_sts,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tlast,
    input  logic [hpc_pkg::CHAR_W-1:0]    i_char,
    input  logic                          i_cfg_valid,
    input  logic [hpc_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [2:0]                    o_status,
    output logic [hpc_pkg::ENT_W-1:0]     o_entry_index,
    output logic [hpc_pkg::CNT_W-1:0]     o_count
);

    localparam int CW = hpc_pkg::CHAR_W;
    localparam int EW = hpc_pkg::ENT_W;
    localparam int KW = hpc_pkg::KEY_AW;
    localparam int LW = hpc_pkg::LEN_W;
    localparam int BW = hpc_pkg::BKT_W;
    localparam int NW = hpc_pkg::CFG_W;
    localparam int HW = hpc_pkg::HASH_W;
    localparam int TW = hpc_pkg::CNT_W;
    localparam int DW = hpc_pkg::DCNT_W;

    // memories
    logic [EW-1:0] m_head  [hpc_pkg::BUCKET_DEPTH];
    logic [KW-1:0] m_start [hpc_pkg::ENTRY_DEPTH];
    logic [LW-1:0] m_len   [hpc_pkg::ENTRY_DEPTH];
    logic [TW-1:0] m_cnt   [hpc_pkg::ENTRY_DEPTH];
    logic [EW-1:0] m_nxt   [hpc_pkg::ENTRY_DEPTH];
    logic [CW-1:0] m_key   [hpc_pkg::KEY_STORE_DEPTH];
    logic [CW-1:0] m_pb    [hpc_pkg::MAX_KEY_LEN];

    logic [NW-1:0]   r_bucket_count;
    logic [BW-1:0]   r_clr_idx;
    logic [HW-1:0]   r_hash;
    logic [LW-1:0]   r_plen;
    logic            r_too_long;
    logic [HW-1:0]   r_dvd;
    logic [NW-1:0]   r_rem;
    logic [NW-1:0]   r_nb;
    logic [DW-1:0]   r_dcnt;
    logic [EW-1:0]   r_e;
    logic [EW-1:0]   r_prev;
    logic [LW-1:0]   r_i;
    logic [EW:0]     r_nfe;
    logic [KW:0]     r_kfill;
    logic [EW-1:0]   r_head_q;
    logic [KW-1:0]   r_start_q;
    logic [LW-1:0]   r_len_q;
    logic [TW-1:0]   r_cnt_q;
    logic [EW-1:0]   r_nxt_q;
    logic [CW-1:0]   r_key_q;
    logic [CW-1:0]   r_pb_q;
    logic [2:0]      r_res_code;
    logic [EW-1:0]   r_res_idx;
    logic [TW-1:0]   r_res_cnt;
    logic            r_out_valid;
    logic [2:0]      r_out_status;
    logic [EW-1:0]   r_out_idx;
    logic [TW-1:0]   r_out_cnt;

    logic [BW-1:0]   w_bkt;
    logic [NW:0]     w_rem2;
    logic [NW:0]     w_rem_sub;
    logic [TW-1:0]   w_cnt_sat;
    logic [KW:0]     w_fill_end;
    logic [NW-1:0]   w_nb_clamp;

    assign w_bkt = r_rem[BW-1:0];

    // config register, always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= hpc_pkg::BUCKET_RESET;
        end else if (i_cfg_valid) begin
            r_bucket_count <= i_cfg_data;
        end
    end

    // modulus clamped to 1..BUCKET_DEPTH
    always_comb begin
        w_nb_clamp = r_bucket_count;
        if (r_bucket_count == '0) w_nb_clamp = NW'(1);
        if (r_bucket_count > hpc_pkg::BUCKET_MAX) w_nb_clamp = hpc_pkg::BUCKET_MAX;
    end

    // bucket head clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // hash, phrase length and too-long flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash     <= hpc_pkg::HASH_SEED;
            r_plen     <= '0;
            r_too_long <= 1'b0;
        end else if (i_cmd.phrase_clr) begin
            r_hash     <= hpc_pkg::HASH_SEED;
            r_plen     <= '0;
            r_too_long <= 1'b0;
        end else if (i_cmd.char_take) begin
            r_hash <= (r_hash << 5) + r_hash + HW'(i_char);
            if (!r_plen[LW-1]) r_plen <= r_plen + 1'b1;
            else r_too_long <= 1'b1;
        end
    end

    // phrase buffer: write on intake, registered read at the char index
    always_ff @(posedge i_clk) begin
        if (i_cmd.char_take && !r_plen[LW-1]) m_pb[r_plen[LW-2:0]] <= i_char;
        r_pb_q <= m_pb[r_i[LW-2:0]];
    end

    // restoring remainder, one hash bit per cycle
    assign w_rem2    = {r_rem, r_dvd[HW-1]};
    assign w_rem_sub = w_rem2 - {1'b0, r_nb};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dvd  <= r_hash;
            r_rem  <= '0;
            r_nb   <= w_nb_clamp;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd  <= r_dvd << 1;
            r_dcnt <= r_dcnt + 1'b1;
            if (w_rem2 >= {1'b0, r_nb}) r_rem <= w_rem_sub[NW-1:0];
            else r_rem <= w_rem2[NW-1:0];
        end
    end

    // bucket heads: clear sweep or link write, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            m_head[r_clr_idx] <= '0;
        end else if (i_cmd.link_wr && r_prev == '0) begin
            m_head[w_bkt] <= r_nfe[EW-1:0];
        end
        r_head_q <= m_head[w_bkt];
    end

    // chain walk pointers and fill pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nfe   <= (EW+1)'(1);
            r_kfill <= '0;
        end else if (i_cmd.link_wr) begin
            r_nfe   <= r_nfe + 1'b1;
            r_kfill <= r_kfill + (KW+1)'(r_plen);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.head_load) begin
            r_e    <= r_head_q;
            r_prev <= '0;
        end else if (i_cmd.ent_next) begin
            r_prev <= r_e;
            r_e    <= r_nxt_q;
        end
        if (i_cmd.idx_clr) r_i <= '0;
        else if (i_cmd.idx_inc) r_i <= r_i + 1'b1;
    end

    assign w_cnt_sat = (r_cnt_q == '1) ? r_cnt_q : r_cnt_q + 1'b1;

    // entry records
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            m_start[r_nfe[EW-1:0]] <= r_kfill[KW-1:0];
            m_len[r_nfe[EW-1:0]]   <= r_plen;
        end
        r_start_q <= m_start[r_e];
        r_len_q   <= m_len[r_e];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) m_cnt[r_nfe[EW-1:0]] <= TW'(1);
        else if (i_cmd.cnt_wr) m_cnt[r_e] <= w_cnt_sat;
        r_cnt_q <= m_cnt[r_e];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) m_nxt[r_nfe[EW-1:0]] <= '0;
        else if (i_cmd.link_wr && r_prev != '0) m_nxt[r_prev] <= r_nfe[EW-1:0];
        r_nxt_q <= m_nxt[r_e];
    end

    // key store: copy writes at fill + index, compare reads at start + index
    always_ff @(posedge i_clk) begin
        if (i_cmd.cp_wr) m_key[r_kfill[KW-1:0] + KW'(r_i)] <= r_pb_q;
        r_key_q <= m_key[r_start_q + KW'(r_i)];
    end

    // result latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_code <= i_cmd.res_code;
            case (i_cmd.res_code)
                hpc_pkg::ST_FOUND: begin
                    r_res_idx <= r_e;
                    r_res_cnt <= w_cnt_sat;
                end
                hpc_pkg::ST_NEW: begin
                    r_res_idx <= r_nfe[EW-1:0];
                    r_res_cnt <= TW'(1);
                end
                default: begin
                    r_res_idx <= '0;
                    r_res_cnt <= '0;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_code;
            r_out_idx    <= r_res_idx;
            r_out_cnt    <= r_res_cnt;
        end
    end

    assign o_m_tvalid    = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_index = r_out_idx;
    assign o_count       = r_out_cnt;

    // status to the sequencer
    assign w_fill_end = r_kfill + (KW+1)'(r_plen);

    always_comb begin
        o_sts          = '0;
        o_sts.s_valid  = i_s_tvalid;
        o_sts.s_last   = i_s_tlast;
        o_sts.clr_last = (r_clr_idx == BW'(hpc_pkg::BUCKET_DEPTH - 1));
        o_sts.div_done = (r_dcnt == DW'(HW));
        o_sts.too_long = r_too_long;
        o_sts.e_zero   = (r_e == '0);
        o_sts.len_eq   = (r_len_q == r_plen);
        o_sts.key_eq   = (r_key_q == r_pb_q);
        o_sts.idx_last = (r_i == r_plen - 1'b1);
        o_sts.ent_full = r_nfe[EW];
        o_sts.key_full = ((KW+1)'(hpc_pkg::KEY_STORE_DEPTH) < w_fill_end) ||
                         (w_fill_end < r_kfill);
        o_sts.out_busy = r_out_valid && !i_m_tready;
    end

endmodule

// ===== src/hashed_phrase_counter_top.sv =====
// ============================================================================
// hashed_phrase_counter_top - phrase occurrence counter, chained hash table
// Hashes phrase characters, looks the phrase up in a chained table and
// counts it, inserting new phrases into the entry and key stores.
// Usage: one character per input beat, tdata[20:0] code point, tlast on
//   the final character; one result beat per phrase; the config channel
//   (bucket count) is always ready, and the user must write it only while
//   idle: the block itself does not enforce this.
// Intake: non-final characters are taken back to back while idle. A phrase
//   end runs the bit-serial hash remainder, the head read, a walk over
//   the chain entries with a compare of each key character, a copy of the
//   key characters on insert, then the update and output hand-off; phrases
//   over 512 characters go straight to the hand-off.
// Reset: the 1024 bucket heads are zeroed one per cycle; no input is taken
//   until the sweep is done.
// Stall: a result waits in the output register; characters of the next
//   phrase are still taken, the next phrase end waits until it frees.
// ============================================================================
module hashed_phrase_counter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [20:0] char_code, [23:21] zero
    input  logic        i_s_tlast,   // last_char
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data,  // bucket_count
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata    // [2:0] status, [18:3] entry_index,
                                     // [50:19] count, [55:51] zero
);

    hpc_pkg::t_cmd w_cmd;
    hpc_pkg::t_sts w_sts;
    logic [2:0]    w_status;
    logic [15:0]   w_idx;
    logic [31:0]   w_cnt;

    assign o_cfg_ready = 1'b1;

    // sequencer
    hpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_ready (o_s_tready)
    );

    // datapath and stores
    hpc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tlast     (i_s_tlast),
        .i_char        (i_s_tdata[20:0]),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_status      (w_status),
        .o_entry_index (w_idx),
        .o_count       (w_cnt)
    );

    assign o_m_tdata = {5'd0, w_cnt, w_idx, w_status};

endmodule

// ===== src/hpc_checker.sv =====
// ============================================================================
// hpc_checker - port-level checks for the phrase counter
// Watches the result stream for handshake hold and result consistency.
// ============================================================================
module hpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] o_m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // status code in range
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] == hpc_pkg::ST_FOUND ||
                        o_m_tdata[2:0] == hpc_pkg::ST_NEW ||
                        o_m_tdata[2:0] == hpc_pkg::ST_ENT_FULL ||
                        o_m_tdata[2:0] == hpc_pkg::ST_KEY_FULL ||
                        o_m_tdata[2:0] == hpc_pkg::ST_TOO_LONG))
        else $error("bad status code");

    // rejected phrases carry no entry and no count
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2:0] == hpc_pkg::ST_ENT_FULL ||
                       o_m_tdata[2:0] == hpc_pkg::ST_KEY_FULL ||
                       o_m_tdata[2:0] == hpc_pkg::ST_TOO_LONG)
        |-> o_m_tdata[50:3] == 48'd0)
        else $error("rejected phrase with entry or count");

    // new entries start at count one in a real entry
    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:0] == hpc_pkg::ST_NEW
        |-> o_m_tdata[50:19] == 32'd1 && o_m_tdata[18:3] != 16'd0)
        else $error("new entry result malformed");

endmodule

bind hashed_phrase_counter_top hpc_checker u_hpc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== tb/hashed_phrase_counter_checker.sv =====
// ============================================================================
// hashed_phrase_counter_checker - result predictor and scoreboard
// Watches the character, config and result channels, keeps its own hash
// table image and compares each result beat with the oldest prediction.
// ============================================================================
module hashed_phrase_counter_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [10:0] i_cfg_data,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int CW = hpc_pkg::CHAR_W;

    // packed from the top down: count, entry, status in the low bits
    typedef struct packed {
        logic [31:0] count;
        logic [15:0] entry;
        logic [2:0]  status;
    } t_phrase_result;

    // shadow copy of the table
    logic [hpc_pkg::CFG_W-1:0]  buckets_cfg;
    int unsigned                head_tbl [hpc_pkg::BUCKET_DEPTH];
    int unsigned                key_start [int unsigned];
    int unsigned                key_len [int unsigned];
    logic [31:0]                occ_count [int unsigned];
    int unsigned                chain_next [int unsigned];
    logic [CW-1:0]              key_mem [int unsigned];
    logic [CW-1:0]              phrase_chars [$];
    logic [hpc_pkg::HASH_W-1:0] djb2;
    bit                         overlong;
    int unsigned                free_entry;
    int unsigned                fill_ptr;
    t_phrase_result             results_due [$];

    function automatic bit same_key(int unsigned e);
        if (key_len[e] != phrase_chars.size()) return 0;
        for (int i = 0; i < phrase_chars.size(); i++)
            if (key_mem[key_start[e] + i] != phrase_chars[i]) return 0;
        return 1;
    endfunction

    // look the finished phrase up and update the table image
    function automatic t_phrase_result count_phrase();
        t_phrase_result r;
        int unsigned nb, b, e, prev;
        r = '0;
        if (overlong) begin
            r.status = hpc_pkg::ST_TOO_LONG;
            return r;
        end
        nb = buckets_cfg;
        if (nb == 0) nb = 1;
        if (nb > hpc_pkg::BUCKET_DEPTH) nb = hpc_pkg::BUCKET_DEPTH;
        b = int'(djb2 % 64'(nb));
        e = head_tbl[b];
        prev = 0;
        while (e != 0) begin
            if (same_key(e)) begin
                if (occ_count[e] != 32'hFFFF_FFFF) occ_count[e]++;
                r.status = hpc_pkg::ST_FOUND;
                r.entry = e[15:0];
                r.count = occ_count[e];
                return r;
            end
            prev = e;
            e = chain_next[e];
        end
        if (free_entry >= hpc_pkg::ENTRY_DEPTH) begin
            r.status = hpc_pkg::ST_ENT_FULL;
            return r;
        end
        if (fill_ptr + phrase_chars.size() > hpc_pkg::KEY_STORE_DEPTH) begin
            r.status = hpc_pkg::ST_KEY_FULL;
            return r;
        end
        e = free_entry;
        foreach (phrase_chars[i]) key_mem[fill_ptr + i] = phrase_chars[i];
        key_start[e] = fill_ptr;
        key_len[e] = phrase_chars.size();
        occ_count[e] = 1;
        chain_next[e] = 0;
        if (prev != 0) chain_next[prev] = e;
        else head_tbl[b] = e;
        fill_ptr += phrase_chars.size();
        free_entry = e + 1;
        r.status = hpc_pkg::ST_NEW;
        r.entry = e[15:0];
        r.count = 1;
        return r;
    endfunction

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        t_phrase_result got, want;
        if (!i_rst_n) begin
            buckets_cfg = hpc_pkg::BUCKET_RESET;
            foreach (head_tbl[i]) head_tbl[i] = 0;
            phrase_chars.delete();
            djb2 = hpc_pkg::HASH_SEED;
            overlong = 0;
            free_entry = 1;
            fill_ptr = 0;
            results_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) buckets_cfg = i_cfg_data;
            if (i_s_tvalid && i_s_tready) begin
                djb2 = djb2 * 33 + 64'(i_s_tdata[CW-1:0]);
                if (phrase_chars.size() < hpc_pkg::MAX_KEY_LEN)
                    phrase_chars.push_back(i_s_tdata[CW-1:0]);
                else
                    overlong = 1;
                if (i_s_tlast) begin
                    results_due.push_back(count_phrase());
                    phrase_chars.delete();
                    djb2 = hpc_pkg::HASH_SEED;
                    overlong = 0;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[50:0];
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = results_due.pop_front();
                    if (got.status != want.status || got.entry != want.entry
                            || got.count != want.count
                            || i_m_tdata[55:51] != '0) begin
                        $display("%0t: mismatch exp st/idx/cnt %0d/%0d/%0d act %0d/%0d/%0d",
                                 $time, want.status, want.entry, want.count,
                                 got.status, got.entry, got.count);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = results_due.size();
    end

endmodule

// ===== tb/hashed_phrase_counter_top_test.sv =====
// ============================================================================
// hashed_phrase_counter_top_test - testbench top for the phrase counter
// Drives phrases in bursts (repeats, collisions, long phrases, wide codes)
// under several bucket counts, stalls the result side, and reports.
// ============================================================================
module hashed_phrase_counter_top_test;

    localparam int CW = hpc_pkg::CHAR_W;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [10:0] cfg_data = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;
    int          fail_count;
    int          pending;
    int          burst_left = 0;

    // known phrases, reused to hit existing entries
    logic [CW-1:0] vocab [16][$];

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    hashed_phrase_counter_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tlast(s_tlast),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata)
    );

    hashed_phrase_counter_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tlast(s_tlast),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // result side stalls: long runs ready, then stall stretches
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!i_rst_n) m_tready <= 0;
        else if (r < 3) m_tready <= 1;
        else if (r < 12) m_tready <= ~m_tready;
        else m_tready <= m_tready | (r < 40);
    end

    // one character beat, with bursts and gaps on the valid line
    task automatic send_char(input logic [CW-1:0] code, input bit last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1;
        s_tdata  <= {3'b000, code};
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic send_phrase(input logic [CW-1:0] chars [$]);
        foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
    endtask

    function automatic logic [CW-1:0] rand_code();
        case ($urandom_range(0, 3))
            0: return CW'($urandom_range(97, 122));
            1: return CW'($urandom_range(0, 3));
            2: return CW'($urandom_range(1114000, 1114111));
            default: return CW'($urandom_range(0, 1114111));
        endcase
    endfunction

    // wait for every predicted result to come out, then write the register
    task automatic drain_and_config(input logic [10:0] value);
        s_tvalid <= 0;
        s_tlast  <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        cfg_valid <= 1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    initial begin
        logic [CW-1:0] ph [$];
        logic [10:0] settings [6];
        settings = '{11'd1, 11'd0, 11'd1024, 11'd2047, 11'd7, 11'd1023};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        // build a vocabulary
        foreach (vocab[v]) begin
            repeat ($urandom_range(1, 6)) vocab[v].push_back(rand_code());
        end
        drain_and_config(11'd1);
        // directed: extremes, zero char, repeats, over-long
        send_phrase('{21'd0});
        send_phrase('{21'd0});
        send_phrase('{21'h1FFFFF});
        send_phrase('{21'd1114111, 21'd0});
        send_phrase('{21'd1114111, 21'd0});
        send_phrase('{21'd0, 21'd1114111});
        ph.delete();
        repeat (hpc_pkg::MAX_KEY_LEN + 1) ph.push_back(rand_code());
        send_phrase(ph);
        send_phrase('{21'd1, 21'd2, 21'd3});
        send_phrase('{21'd1, 21'd2});
        for (int k = 0; k < 6; k++) begin
            drain_and_config(settings[k]);
            repeat (5) begin
                int pick;
                pick = $urandom_range(0, 99);
                ph.delete();
                if (pick < 60) begin
                    ph = vocab[$urandom_range(0, 15)];
                end else begin
                    repeat ($urandom_range(1, 8)) ph.push_back(rand_code());
                end
                send_phrase(ph);
            end
        end
        s_tvalid <= 0;
        s_tlast  <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
